// ===== src/bst_pkg.sv =====
`default_nettype none

package bst_pkg;

    localparam int CAPACITY   = 64;
    localparam int ELEM_BITS  = 16;
    localparam int CNT_W      = $clog2(CAPACITY + 1);
    localparam int PRE_LEVELS = $clog2(CAPACITY);

    // Widths of the stream fields; these are fixed by the port layout.
    localparam int IN_ELEM_W  = 16;
    localparam int OP_W       = 2;
    localparam int OUT_CNT_W  = 7;
    localparam int OUT_DATA_W = 16;

    typedef logic [ELEM_BITS-1:0] elem_t;
    typedef logic [CNT_W-1:0]     count_t;

    typedef enum logic [OP_W-1:0] {
        OP_CLEAR  = 2'd0,
        OP_INSERT = 2'd1,
        OP_DELETE = 2'd2,
        OP_QUERY  = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CMP,
        ST_UPD
    } state_t;

    // Per-cell update controls.
    typedef struct packed {
        logic load_new;
        logic shift;
    } cell_ctl_t;

    // Result transaction, highest bit first.
    typedef struct packed {
        logic [OUT_DATA_W-12:0] pad;
        logic                   now_full;
        logic                   now_empty;
        logic [OUT_CNT_W-1:0]   element_count;
        logic                   status;
        logic                   was_member;
    } result_t;

endpackage

`default_nettype wire

// ===== src/bst_cell.sv =====
`default_nettype none

module bst_cell (
    input  logic                  aclk,
    input  logic                  cmp_en,
    input  logic                  occupied,
    input  bst_pkg::elem_t        key,
    input  bst_pkg::cell_ctl_t    ctl,
    input  bst_pkg::elem_t        right_data,
    output bst_pkg::elem_t        data,
    output logic                  hit
);
    import bst_pkg::*;

    elem_t data_reg, data_next;
    logic  hit_reg, hit_next;

    always_comb begin
        data_next = data_reg;
        if (ctl.load_new) begin
            data_next = key;
        end else if (ctl.shift) begin
            data_next = right_data;
        end
    end

    // Only entries below the count may match.
    always_comb begin
        hit_next = hit_reg;
        if (cmp_en) begin
            hit_next = occupied && (data_reg == key);
        end
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
        hit_reg  <= hit_next;
    end

    assign data = data_reg;
    assign hit  = hit_reg;

endmodule

`default_nettype wire

// ===== src/bounded_set_table.sv =====
`default_nettype none
// Channel  | Ports                       | Contents
// ---------+-----------------------------+--------------------------------------------
// input    | s_tvalid s_tready s_tdata   | tuser: operation; tdata: element
//          | s_tuser                     |
// result   | m_tvalid m_tready m_tdata   | was_member, status, count, empty, full
//
// Each transaction passes three steps: accept, per-cell compare (registered hit),
// then prefix-OR of hits and update of the cell chain plus result load; a new one is accepted only back in idle.
// m_tvalid rises at the edge that leaves the update step; while the result waits on m_tready
// the next transaction is accepted and held at the update step until the slot frees.
// Reset clears the count and control; cell contents are left as they are.

module bounded_set_table (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [bst_pkg::IN_ELEM_W-1:0] s_tdata,   // [15:0] element
    input  logic [bst_pkg::OP_W-1:0]      s_tuser,   // [1:0] operation
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [bst_pkg::OUT_DATA_W-1:0] m_tdata   // [0] was_member, [1] status,
                                                      // [8:2] element_count,
                                                      // [9] now_empty, [10] now_full
);
    import bst_pkg::*;

    state_t  state_reg, state_next;
    op_t     op_reg, op_next;
    elem_t   elem_reg, elem_next;
    count_t  count_reg, count_next;
    result_t res_reg, res_next;
    logic    m_tvalid_reg, m_tvalid_next;

    logic cmp_en;
    logic upd_go;
    logic accept;

    elem_t     cell_data [CAPACITY];
    logic      [CAPACITY-1:0] hit_vec;
    logic      [CAPACITY-1:0] occ_vec;
    logic      [CAPACITY-1:0] pre_vec;
    cell_ctl_t cell_ctl  [CAPACITY];

    logic member;
    logic is_full;
    logic do_insert;
    logic do_delete;

    // ---------------- cell chain ----------------
    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        elem_t right;
        if (i == CAPACITY - 1) begin : g_last
            assign right = cell_data[i];
        end else begin : g_mid
            assign right = cell_data[i+1];
        end

        assign occ_vec[i] = CNT_W'(i) < count_reg;
        assign cell_ctl[i].load_new = do_insert && (count_reg == CNT_W'(i));
        assign cell_ctl[i].shift    = do_delete && pre_vec[i];

        bst_cell u_cell (
            .aclk       (aclk),
            .cmp_en     (cmp_en),
            .occupied   (occ_vec[i]),
            .key        (elem_reg),
            .ctl        (cell_ctl[i]),
            .right_data (right),
            .data       (cell_data[i]),
            .hit        (hit_vec[i])
        );
    end

    // Inclusive prefix-OR: set from the matching cell upward.
    always_comb begin
        pre_vec = hit_vec;
        for (int lvl = 0; lvl < PRE_LEVELS; lvl++) begin
            pre_vec = pre_vec | (pre_vec << (1 << lvl));
        end
    end

    assign member    = pre_vec[CAPACITY-1];
    assign is_full   = (count_reg == CNT_W'(CAPACITY));
    assign upd_go    = (state_reg == ST_UPD) && (!m_tvalid_reg || m_tready);
    assign do_insert = upd_go && (op_reg == OP_INSERT) && !member && !is_full;
    assign do_delete = upd_go && (op_reg == OP_DELETE) && member;

    // ---------------- sequencer ----------------
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) state_next = ST_CMP;
            end
            ST_CMP: begin
                state_next = ST_UPD;
            end
            ST_UPD: begin
                if (upd_go) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        s_tready = 1'b0;
        cmp_en   = 1'b0;
        unique case (state_reg)
            ST_IDLE: s_tready = 1'b1;
            ST_CMP:  cmp_en   = 1'b1;
            ST_UPD:  ;
            default: ;
        endcase
    end

    assign accept = s_tvalid && s_tready;

    // ---------------- datapath ----------------
    always_comb begin
        op_next   = op_reg;
        elem_next = elem_reg;
        if (accept) begin
            op_next   = op_t'(s_tuser);
            elem_next = elem_t'(s_tdata);
        end
    end

    always_comb begin
        count_next = count_reg;
        if (upd_go) begin
            if (op_reg == OP_CLEAR) begin
                count_next = '0;
            end else if (do_insert) begin
                count_next = count_reg + CNT_W'(1);
            end else if (do_delete) begin
                count_next = count_reg - CNT_W'(1);
            end
        end
    end

    always_comb begin
        res_next      = res_reg;
        m_tvalid_next = m_tvalid_reg;
        if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
        if (upd_go) begin
            m_tvalid_next          = 1'b1;
            res_next.pad           = '0;
            res_next.was_member    = (op_reg != OP_CLEAR) && member;
            res_next.status        = (op_reg == OP_INSERT) && !member && is_full;
            res_next.element_count = OUT_CNT_W'(count_next);
            res_next.now_empty     = (count_next == '0);
            res_next.now_full      = (count_next == CNT_W'(CAPACITY));
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            count_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg   <= op_next;
        elem_reg <= elem_next;
        res_reg  <= res_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = res_reg;

    // ---------------- checks ----------------
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(CAPACITY))
        else $error("count above capacity");

    a_result_follows_update: assert property (@(posedge aclk) disable iff (!aresetn)
        upd_go |=> m_tvalid_reg)
        else $error("update without result");

    a_reject_only_full: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid_reg && res_reg.status) |-> res_reg.now_full)
        else $error("reject while not full");

    a_count_step: assert property (@(posedge aclk) disable iff (!aresetn)
        (upd_go && op_reg != OP_CLEAR) |=>
            (count_reg == $past(count_reg) ||
             count_reg == $past(count_reg) + CNT_W'(1) ||
             count_reg == $past(count_reg) - CNT_W'(1)))
        else $error("count moved by more than one");

    a_insert_no_delete: assert property (@(posedge aclk) disable iff (!aresetn)
        !(do_insert && do_delete))
        else $error("insert and delete together");

endmodule

`default_nettype wire

// ===== tb/bounded_set_table_test.sv =====
`timescale 1ns / 1ps

module bounded_set_table_test;
    import bst_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 24;
    localparam int RANDOM_ITEMS   = 950;

    // Tracks the set contents and queues the expected result per accepted request.
    class membership_scoreboard;
        elem_t       held [CAPACITY];
        int unsigned count = 0;
        result_t     expected_q [$];
        int          errors = 0;

        function void note_request(op_t op, elem_t e);
            result_t     r;
            int unsigned pos;
            pos = count;
            for (int i = 0; i < count; i++) begin
                if (held[i] == e) begin
                    pos = i;
                    break;
                end
            end
            r = '0;
            r.was_member = (op != OP_CLEAR) && (pos < count);
            case (op)
                OP_CLEAR: begin
                    count = 0;
                end
                OP_INSERT: begin
                    if (pos == count) begin
                        if (count >= CAPACITY) begin
                            r.status = 1'b1;
                        end else begin
                            held[count] = e;
                            count++;
                        end
                    end
                end
                OP_DELETE: begin
                    if (pos < count) begin
                        // close the gap, keep insertion order
                        for (int j = pos + 1; j < count; j++) held[j-1] = held[j];
                        count--;
                    end
                end
                default: ;
            endcase
            r.element_count = OUT_CNT_W'(count);
            r.now_empty     = (count == 0);
            r.now_full      = (count == CAPACITY);
            expected_q.push_back(r);
        endfunction

        function void compare_field(string name, int unsigned want, int unsigned got);
            if (want != got) begin
                $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name,
                         want, got);
                errors++;
            end
        endfunction

        function void check_result(result_t got);
            result_t want;
            if (expected_q.size() == 0) begin
                $display("%0t ns: unexpected result transaction, expected none, actual %h",
                         $time, got);
                errors++;
                return;
            end
            want = expected_q.pop_front();
            compare_field("was_member",    want.was_member,    got.was_member);
            compare_field("status",        want.status,        got.status);
            compare_field("element_count", want.element_count, got.element_count);
            compare_field("now_empty",     want.now_empty,     got.now_empty);
            compare_field("now_full",      want.now_full,      got.now_full);
        endfunction
    endclass

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [IN_ELEM_W-1:0]  s_tdata = '0;
    logic [OP_W-1:0]       s_tuser = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;

    membership_scoreboard sb = new;
    bit send_calm = 1'b0;
    bit recv_calm = 1'b0;

    bounded_set_table dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // Gap before each transaction; a calm stretch runs with no gaps at all.
    function automatic int unsigned draw_gap(inout bit calm);
        if ($urandom_range(0, 29) == 0) calm = !calm;
        return calm ? 0 : $urandom_range(0, 18);
    endfunction

    // Called and returns at a falling edge.
    task automatic send_request(op_t op, elem_t e);
        int unsigned gap;
        gap = draw_gap(send_calm);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= e;
        do @(posedge aclk); while (!s_tready);
        sb.note_request(op, e);
        @(negedge aclk);
    endtask

    task automatic run_directed();
        send_request(OP_CLEAR,  16'h0000);
        send_request(OP_QUERY,  16'h0000);   // query on empty
        send_request(OP_DELETE, 16'hFFFF);   // delete from empty
        send_request(OP_INSERT, 16'h0000);
        send_request(OP_INSERT, 16'hFFFF);
        send_request(OP_INSERT, 16'hA5A5);
        send_request(OP_INSERT, 16'h5A5A);
        send_request(OP_INSERT, 16'h0000);   // already present
        send_request(OP_QUERY,  16'hFFFF);
        send_request(OP_QUERY,  16'h1234);
        send_request(OP_DELETE, 16'h1234);   // absent
        send_request(OP_DELETE, 16'h0000);   // head, rest shifts down
        send_request(OP_QUERY,  16'hA5A5);
        send_request(OP_DELETE, 16'h5A5A);   // tail
        send_request(OP_DELETE, 16'hA5A5);
        send_request(OP_DELETE, 16'hFFFF);   // back to empty
        send_request(OP_CLEAR,  16'hFFFF);   // clear on empty, element ignored
        send_request(OP_INSERT, 16'h8001);
        send_request(OP_CLEAR,  16'h7FFE);   // clear on non-empty
        send_request(OP_QUERY,  16'h8001);
    endtask

    // Episodes mostly over a small value pool, some over random values, so hits, shifts and the full set are reached.
    task automatic run_random(int total);
        int          left;
        int unsigned kind, len, span, pick;
        elem_t       base, e;
        op_t         op;
        left = total;
        while (left > 0) begin
            kind = $urandom_range(0, 9);
            base = elem_t'($urandom);
            if (kind <= 3) begin
                span = $urandom_range(64, 96);
                len  = $urandom_range(90, 160);
                if ($urandom_range(0, 1) == 0) begin
                    send_request(OP_CLEAR, elem_t'($urandom));
                    left--;
                end
            end else if (kind <= 7) begin
                span = $urandom_range(4, 40);
                len  = $urandom_range(20, 80);
            end else begin
                span = 0;
                len  = $urandom_range(10, 40);
            end
            for (int i = 0; i < len && left > 0; i++) begin
                pick = $urandom_range(0, 99);
                if (span == 0) begin
                    e  = elem_t'($urandom);
                    op = op_t'($urandom_range(0, 3));
                end else begin
                    e = base + elem_t'($urandom_range(0, span - 1));
                    if (kind <= 3)
                        op = (pick < 80) ? OP_INSERT : (pick < 90) ? OP_QUERY : OP_DELETE;
                    else
                        op = (pick < 3)  ? OP_CLEAR  : (pick < 40) ? OP_INSERT :
                             (pick < 70) ? OP_DELETE : OP_QUERY;
                end
                send_request(op, e);
                left--;
            end
        end
    endtask

    // Result side back-pressure.
    initial begin
        int unsigned stall;
        wait (aresetn === 1'b1);
        @(negedge aclk);
        forever begin
            stall = draw_gap(recv_calm);
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
            @(negedge aclk);
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) sb.check_result(result_t'(m_tdata));
    end

    initial begin
        int quiet;
        quiet = 0;
        wait (aresetn === 1'b1);
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet = 0;
            else quiet++;
        end
        $display("Test completed with failures");
        $finish;
    end

    initial begin
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);
        run_directed();
        run_random(RANDOM_ITEMS);
        s_tvalid <= 1'b0;
        while (sb.expected_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (sb.errors == 0 && sb.expected_q.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
